// File: hdl/iap_pkg.sv
package iap_pkg;

   localparam int VALUE_W        = 64;
   localparam int FIELD_W        = 6;
   localparam int FUNC_W         = 2;
   localparam int REQ_DATA_W     = 80;
   localparam int REQ_USER_W     = 3;
   localparam int RSP_DATA_W     = 8;
   localparam int DIG_CNT_W      = 5;
   localparam int LEN_W          = 7;
   localparam int VALUE_BITS_DEF = 64;
   localparam int MAX_FIELD_DEF  = 63;

   localparam logic [FUNC_W-1:0] FUNC_DEC    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_HEX_LO = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_HEX_UP = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOWER = 8'h61;
   localparam logic [7:0] CH_UPPER = 8'h41;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic               wide;
      logic [VALUE_W-1:0] value;
      logic               zero_fill;
      logic [FIELD_W-1:0] field_width;
      logic [FIELD_W-1:0] precision;
   } req_type;

   // conversion result handed from converter to emitter
   typedef struct packed {
      logic                 neg;
      logic                 upper;
      logic                 zero_fill;
      logic [FIELD_W-1:0]   field_width;
      logic [FIELD_W-1:0]   precision;
      logic [DIG_CNT_W-1:0] ndig;
   } job_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UPPER : CH_LOWER;
      if (d < 4'd10) begin
         digit_char = CH_ZERO + {4'd0, d};
      end else begin
         digit_char = base + {4'd0, d - 4'd10};
      end
   endfunction

endpackage

// File: hdl/iap_conv.sv
module iap_conv #(
   parameter int VALUE_BITS = iap_pkg::VALUE_BITS_DEF,
   parameter int DIGITS     = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  iap_pkg::req_type        req,
   output logic                    job_valid,
   input  logic                    job_ready,
   output iap_pkg::job_type        job,
   output logic [DIGITS*4-1:0]     digits
);
   import iap_pkg::*;

   localparam int BCD_W     = DIGITS * 4;
   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_CONV = 2'd1;
   localparam logic [1:0] C_SCAN = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIG_CNT_W-1:0]  nd_ff, nd_in;
   job_type               job_ff, job_in;

   logic [VALUE_BITS-1:0] mask, masked, mag_val;
   logic [BCD_W-1:0]      adj;
   logic                  sign_bit, neg, hex, accept, scan_done;

   assign req_ready = (state_ff == C_IDLE);
   assign accept    = req_valid && req_ready;
   assign scan_done = (bcd_ff[BCD_W-1 -: 4] != 4'd0) || (nd_ff == DIG_CNT_W'(1));
   assign job_valid = (state_ff == C_SCAN) && scan_done;
   assign job       = job_ff;
   assign digits    = bcd_ff;

   // operand size, sign and magnitude
   always_comb begin
      mask     = req.wide ? '1 : VALUE_BITS'(32'hffff_ffff);
      masked   = req.value[VALUE_BITS-1:0] & mask;
      sign_bit = req.wide ? req.value[VALUE_BITS-1] : req.value[31];
      hex      = (req.func != FUNC_DEC);
      neg      = !hex && sign_bit;
      mag_val  = neg ? ((~masked + 1'b1) & mask) : masked;
   end

   // add-3 on every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                    : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      nd_in    = nd_ff;
      job_in   = job_ff;
      case (state_ff)
         C_IDLE: begin
            if (accept) begin
               job_in.neg         = neg;
               job_in.upper       = (req.func >= FUNC_HEX_UP);
               job_in.zero_fill   = req.zero_fill;
               job_in.field_width = req.field_width;
               job_in.precision   = req.precision;
               job_in.ndig        = DIG_CNT_W'(DIGITS);
               nd_in              = DIG_CNT_W'(DIGITS);
               mag_in             = req.wide ? mag_val : (mag_val << (VALUE_BITS - 32));
               cnt_in             = req.wide ? BIT_CNT_W'(VALUE_BITS) : BIT_CNT_W'(32);
               if (hex) begin
                  bcd_in   = BCD_W'(mag_val);
                  state_in = C_SCAN;
               end else begin
                  bcd_in   = '0;
                  state_in = C_CONV;
               end
            end
         end
         C_CONV: begin
            bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == BIT_CNT_W'(1)) begin
               state_in = C_SCAN;
            end
         end
         C_SCAN: begin
            // strip leading zero digits, keep at least one
            if (!scan_done) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               nd_in  = nd_ff - 1'b1;
            end
            job_in.ndig = nd_in;
            if (job_valid && job_ready) begin
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      nd_ff  <= nd_in;
      job_ff <= job_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != C_IDLE)
      else $error("converter stayed idle after taking a word");

   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_CONV |-> cnt_ff != '0)
      else $error("bit counter ran out during conversion");

   a_job_aligned: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> nd_ff != '0 && job.ndig == nd_ff)
      else $error("handed-off digit count inconsistent");

endmodule

// File: hdl/iap_emit.sv
module iap_emit #(
   parameter int MAX_FIELD = iap_pkg::MAX_FIELD_DEF,
   parameter int DIGITS    = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  iap_pkg::job_type              job,
   input  logic [DIGITS*4-1:0]           digits,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [iap_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import iap_pkg::*;

   localparam int BCD_W = DIGITS * 4;
   localparam logic [FIELD_W-1:0] MAX_F = FIELD_W'(MAX_FIELD);

   logic                  busy_ff, busy_in;
   logic [LEN_W-1:0]      sp_ff, sp_in, zc_ff, zc_in;
   logic                  sign_ff, sign_in, upper_ff, upper_in;
   logic [DIG_CNT_W-1:0]  dc_ff, dc_in;
   logic [BCD_W-1:0]      dig_ff, dig_in;
   logic                  vld_ff, vld_in, last_ff, last_in;
   logic [7:0]            ch_ff, ch_in;

   logic                  take, adv;
   logic [LEN_W-1:0]      fw7, pr7, n7, pz, body, pad;

   assign job_ready  = !busy_ff;
   assign take       = job_valid && !busy_ff;
   assign adv        = busy_ff && (!vld_ff || rsp_tready);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = ch_ff;
   assign rsp_tlast  = last_ff;

   // layout lengths, limits applied
   always_comb begin
      fw7  = {1'b0, (job.field_width > MAX_F) ? MAX_F : job.field_width};
      pr7  = {1'b0, (job.precision > MAX_F) ? MAX_F : job.precision};
      n7   = LEN_W'(job.ndig);
      pz   = (pr7 > n7) ? pr7 - n7 : '0;
      body = LEN_W'(job.neg) + pz + n7;
      pad  = (fw7 > body) ? fw7 - body : '0;
   end

   always_comb begin
      busy_in  = busy_ff;
      sp_in    = sp_ff;
      zc_in    = zc_ff;
      sign_in  = sign_ff;
      upper_in = upper_ff;
      dc_in    = dc_ff;
      dig_in   = dig_ff;
      vld_in   = vld_ff && !rsp_tready;
      last_in  = last_ff;
      ch_in    = ch_ff;
      if (take) begin
         busy_in  = 1'b1;
         sp_in    = job.zero_fill ? '0 : pad;
         zc_in    = job.zero_fill ? pad + pz : pz;
         sign_in  = job.neg;
         upper_in = job.upper;
         dc_in    = job.ndig;
         dig_in   = digits;
      end else if (adv) begin
         vld_in  = 1'b1;
         last_in = 1'b0;
         if (sp_ff != '0) begin
            ch_in = CH_SPACE;
            sp_in = sp_ff - 1'b1;
         end else if (sign_ff) begin
            ch_in   = CH_MINUS;
            sign_in = 1'b0;
         end else if (zc_ff != '0) begin
            ch_in = CH_ZERO;
            zc_in = zc_ff - 1'b1;
         end else begin
            ch_in  = digit_char(dig_ff[BCD_W-1 -: 4], upper_ff);
            dig_in = {dig_ff[BCD_W-5:0], 4'd0};
            dc_in  = dc_ff - 1'b1;
            if (dc_ff == DIG_CNT_W'(1)) begin
               last_in = 1'b1;
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
      sp_ff    <= sp_in;
      zc_ff    <= zc_in;
      sign_ff  <= sign_in;
      upper_ff <= upper_in;
      dc_ff    <= dc_in;
      dig_ff   <= dig_in;
      last_ff  <= last_in;
      ch_ff    <= ch_in;
   end

   a_busy_digits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> dc_ff != '0)
      else $error("emitter busy with no digits left");

   a_end_marks_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy_ff) |-> vld_ff && last_ff)
      else $error("emitter finished without a final character");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy_ff)
      else $error("emitter did not start on a taken job");

endmodule

// File: hdl/integer_to_padded_ascii.sv
// Integer to padded ASCII: one printf-style integer conversion per request word.
// Request channel (req_*): tdata carries value, zero_fill, field_width and precision,
// tuser carries the conversion kind and operand size. A word is taken when
// tvalid and tready are both high; tready is high while the converter is free.
// Response channel (rsp_*): one ASCII character per word, tlast on the final one.
// Decimal words run a bit-serial double-dabble, one operand bit per cycle
// (32 or VALUE_BITS bits), hex words skip it; then leading zero digits are
// stripped one digit per cycle (at most DIGITS-1 digits) and the digits are
// handed to the emitter. The emitter sends one character per cycle from its
// output register while the receiver is ready. The next request converts while
// the previous one is still being emitted. Reset (synchronous, active high)
// drops any word in flight and empties the output register. A stalled receiver
// holds the current character; the emitter and then the converter stop behind
// it, and no character is lost.
module integer_to_padded_ascii #(
   parameter int VALUE_BITS = iap_pkg::VALUE_BITS_DEF,
   parameter int MAX_FIELD  = iap_pkg::MAX_FIELD_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // value[63:0], zero_fill[64], field_width[70:65], precision[76:71], zeros above
   input  logic [iap_pkg::REQ_DATA_W-1:0] req_tdata,
   // func[1:0], wide[2]
   input  logic [iap_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // ch[7:0]
   output logic [iap_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import iap_pkg::*;

   // decimal digits needed for VALUE_BITS bits (0.30103 ~ log10 2)
   localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

   req_type              req;
   job_type              job;
   logic                 job_valid, job_ready;
   logic [DIGITS*4-1:0]  digits;

   // unpack the request word
   assign req.value       = req_tdata[VALUE_W-1:0];
   assign req.zero_fill   = req_tdata[VALUE_W];
   assign req.field_width = req_tdata[VALUE_W+1 +: FIELD_W];
   assign req.precision   = req_tdata[VALUE_W+1+FIELD_W +: FIELD_W];
   assign req.func        = req_tuser[FUNC_W-1:0];
   assign req.wide        = req_tuser[FUNC_W];

   // bit-serial binary to digit conversion and leading-zero strip
   iap_conv #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .digits    (digits)
   );

   // padding, sign and digit sequencer with output register
   iap_emit #(
      .MAX_FIELD (MAX_FIELD),
      .DIGITS    (DIGITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .digits     (digits),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: test/tb_integer_to_padded_ascii.sv
`timescale 1ns / 100ps

// Testbench for integer_to_padded_ascii.
// Conversion requests are driven on the req_ stream. For each accepted word the
// expected ASCII text is built here and queued one character at a time. Every
// rsp_ word is checked against the head of that queue (character and tlast).
// Both sides idle at random, and once the receiver holds off for a long
// stretch so that the block backs up into its request side.
module tb_integer_to_padded_ascii;
   import iap_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;   // unused selector, acts as upper hex
   localparam int HOLD_CYCLES = 1500;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   text_char_type pending_chars[$];
   int         mismatch_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   logic       hold_go = 1'b0;
   int         hold_count = 0;

   integer_to_padded_ascii u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Builds the printf-style text for one request and queues it.
   // Layout: space pad, sign, zero pad, precision zeros, digits.
   function automatic void format_conversion(input req_type r);
      logic [63:0] mag;
      logic        neg;
      logic        hex;
      logic [3:0]  d;
      logic [7:0]  digits[$];
      logic [7:0]  text[$];
      int          prec;
      int          fw;
      int          pz;
      int          body;
      int          pad;
      hex  = (r.func != FUNC_DEC);
      prec = r.precision;
      fw   = r.field_width;
      // narrow operand: only the low 32 bits count, bit 31 is the sign
      mag = r.wide ? r.value : {32'd0, r.value[31:0]};
      neg = !hex && (r.wide ? mag[63] : mag[31]);
      // most negative value falls out right: magnitude is read unsigned
      if (neg) begin
         mag = r.wide ? (64'd0 - mag) : {32'd0, 32'd0 - mag[31:0]};
      end
      do begin
         if (hex) begin
            d   = mag[3:0];
            mag = mag >> 4;
         end else begin
            d   = 4'(mag % 64'd10);
            mag = mag / 64'd10;
         end
         if (d < 4'd10) begin
            digits.push_front(CH_ZERO + 8'(d));
         end else begin
            digits.push_front((r.func[1] ? CH_UPPER : CH_LOWER) + 8'(d - 4'd10));
         end
      end while (mag != 64'd0);
      pz   = (prec > digits.size()) ? prec - digits.size() : 0;
      body = (neg ? 1 : 0) + pz + digits.size();
      pad  = (fw > body) ? fw - body : 0;
      if (!r.zero_fill) begin
         repeat (pad) text.push_back(CH_SPACE);
      end
      if (neg) begin
         text.push_back(CH_MINUS);
      end
      if (r.zero_fill) begin
         repeat (pad) text.push_back(CH_ZERO);
      end
      repeat (pz) text.push_back(CH_ZERO);
      foreach (digits[i]) text.push_back(digits[i]);
      foreach (text[i]) pending_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
   endfunction

   function automatic req_type conv(input logic [FUNC_W-1:0] func, input logic wide,
                                    input logic [63:0] value, input logic zero_fill,
                                    input logic [5:0] field_width, input logic [5:0] precision);
      req_type r;
      r.func        = func;
      r.wide        = wide;
      r.value       = value;
      r.zero_fill   = zero_fill;
      r.field_width = field_width;
      r.precision   = precision;
      return r;
   endfunction

   // Offers one request word; returns at the edge where it is taken.
   task automatic send_conv(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'd0, r.precision, r.field_width, r.zero_fill, r.value};
      req_tuser  <= {r.wide, r.func};
      do @(posedge clock); while (!req_tready);
      format_conversion(r);
   endtask

   task automatic wait_for_text_drained();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // Receiver: random back-pressure, plus a single long hold-off on request.
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Checker: every response word against the oldest queued character.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected word ch %h last %b", $time, rsp_tdata, rsp_tlast);
            end
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== want.ch || rsp_tlast !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch ch exp %h got %h, last exp %b got %b",
                           $time, want.ch, rsp_tdata, want.last, rsp_tlast);
               end
            end
         end
      end
   end

   // Extremes, every conversion kind and the awkward corners.
   task automatic test_directed_cases();
      send_conv(conv(FUNC_DEC,    1'b0, 64'd0, 1'b0, 6'd0, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b1, 64'd0, 1'b1, 6'd63, 6'd0));
      // most negative, 64 and 32 bits (upper bits set but ignored)
      send_conv(conv(FUNC_DEC,    1'b1, 64'h8000_0000_0000_0000, 1'b0, 6'd0, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b0, 64'hFFFF_FFFF_8000_0000, 1'b0, 6'd0, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b0, 64'h1234_5678_FFFF_FFFF, 1'b0, 6'd4, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 6'd0, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd6, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b0, 64'hFFFF_FFFF_7FFF_FFFF, 1'b0, 6'd0, 6'd0));
      send_conv(conv(FUNC_HEX_LO, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0, 6'd0));
      send_conv(conv(FUNC_HEX_UP, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 6'd20, 6'd0));
      send_conv(conv(FUNC_SPARE,  1'b1, 64'hDEAD_BEEF_CAFE_F00D, 1'b1, 6'd20, 6'd0));
      // narrow hex drops the top half
      send_conv(conv(FUNC_HEX_LO, 1'b0, 64'hFFFF_FFFF_0000_ABCD, 1'b0, 6'd0, 6'd0));
      // pointer style
      send_conv(conv(FUNC_HEX_LO, 1'b1, 64'h0000_7FFF_1234_5678, 1'b1, 6'd16, 6'd0));
      // hex of a negative pattern stays unsigned
      send_conv(conv(FUNC_HEX_UP, 1'b0, 64'h0000_0000_8000_0000, 1'b0, 6'd0, 6'd0));
      // zero fill alongside precision: sign, fill, precision zeros, digits
      send_conv(conv(FUNC_DEC,    1'b1, 64'hFFFF_FFFF_FFFF_FFD6, 1'b1, 6'd12, 6'd5));
      send_conv(conv(FUNC_DEC,    1'b0, 64'h0000_0000_FFFF_FFF9, 1'b0, 6'd10, 6'd0));
      // longest text: sign plus 63 digits
      send_conv(conv(FUNC_DEC,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd63, 6'd63));
      send_conv(conv(FUNC_HEX_LO, 1'b1, 64'd0, 1'b0, 6'd0, 6'd1));
      send_conv(conv(FUNC_HEX_UP, 1'b1, 64'd0, 1'b0, 6'd63, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b1, 64'd123456789, 1'b0, 6'd3, 6'd0));
      send_conv(conv(FUNC_DEC,    1'b0, 64'd255, 1'b1, 6'd2, 6'd63));
      send_conv(conv(FUNC_HEX_LO, 1'b0, 64'h0000_0000_ABCD_EF01, 1'b1, 6'd63, 6'd63));
      send_conv(conv(FUNC_DEC,    1'b1, 64'd0 - 64'd100, 1'b0, 6'd8, 6'd6));
      wait_for_text_drained();
   endtask

   task automatic test_random_conversions(input int n_words);
      req_type r;
      for (int i = 0; i < n_words; i++) begin
         r.func      = FUNC_W'($urandom_range(3));
         r.wide      = 1'($urandom_range(1));
         r.zero_fill = 1'($urandom_range(1));
         case ($urandom_range(3))
            0: r.value = {$urandom, $urandom};
            1: r.value = {$urandom, $urandom} >> $urandom_range(63);
            2: r.value = 64'($urandom_range(999));
            default: r.value = 64'd0 - ({$urandom, $urandom} >> $urandom_range(63));
         endcase
         // mostly short fields, now and then anything up to the limit
         r.field_width = 6'(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(12));
         r.precision   = 6'(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(12));
         send_conv(r);
      end
      wait_for_text_drained();
   endtask

   // Receiver stops dead while requests keep coming: block must back up.
   task automatic test_receiver_backpressure();
      hold_go <= 1'b1;
      for (int i = 0; i < 10; i++) begin
         send_conv(conv(FUNC_DEC, 1'b1, {$urandom, $urandom}, 1'($urandom_range(1)),
                        6'd40, 6'($urandom_range(24))));
      end
      wait_for_text_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 55;
      test_directed_cases();
      test_random_conversions(40);

      send_idle_pct = 55;
      recv_idle_pct = 25;
      test_random_conversions(40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_conversions(40);
      test_receiver_backpressure();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/iap_pkg.sv
hdl/iap_conv.sv
hdl/iap_emit.sv
hdl/integer_to_padded_ascii.sv
test/tb_integer_to_padded_ascii.sv
